[hw/rtl/text_console_writer_assert.svh]
// Assertion macros used by the console writer RTL.
// Each macro is used on a line of its own and supplies its own semicolon.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Condition in a cycle implies an expression in the same cycle.
`define TCW_ASSERT_IMPL(label, clk_s, rst_s, cond, expr) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |-> (expr)) \
    else $error("text console writer: same-cycle check failed");

// Condition in a cycle implies an expression in the following cycle.
`define TCW_ASSERT_NEXT(label, clk_s, rst_s, cond, expr) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |=> (expr)) \
    else $error("text console writer: next-cycle check failed");

`endif

[hw/rtl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_LINES   = 25;

  // Field widths of the request and result channels.
  localparam int KIND_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int DATA_W    = 16;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Control characters and the blank cell.
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [7:0]        TEXT_ATTR  = 8'h07;
  localparam logic [DATA_W-1:0] BLANK_CELL = {TEXT_ATTR, CH_SPACE};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // latch the incoming request
    logic exec;        // apply a put, clear or idle kind and load the result
    logic start_fill;  // begin blanking the cursor row
    logic fill_step;   // blank one cell of the cursor row
    logic div_load;    // register the row of the read index
    logic rd_capture;  // read the screen memory and register the row flag
    logic load_read;   // load the result of a read
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_fill;   // a printable byte targets a row still marked blank
    logic is_read;     // the held request is a read
    logic fill_last;   // the row sweep is at its last column
    logic out_free;    // the result register can take a new result
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/tcw_ctrl.sv]
`default_nettype none

module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcw_pkg::status_t  status,
  output tcw_pkg::cmd_t     cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_RADDR = 3'd3;
  localparam logic [2:0] ST_RDATA = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of one request at a time.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.need_fill) begin
          cmd.start_fill = 1'b1;
          state_next     = ST_FILL;
        end else if (status.is_read) begin
          cmd.div_load = 1'b1;
          state_next   = ST_RADDR;
        end else if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FILL: begin
        // The row is blanked, then the put is applied from the execute state.
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = ST_EXEC;
        end
      end
      ST_RADDR: begin
        cmd.rd_capture = 1'b1;
        state_next     = ST_RDATA;
      end
      ST_RDATA: begin
        if (status.out_free) begin
          cmd.load_read = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);

endmodule

`default_nettype wire

[hw/rtl/tcw_dp.sv]
`default_nettype none

module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int LINES   = tcw_pkg::DEF_LINES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tcw_pkg::cmd_t                  cmd,
  output tcw_pkg::status_t               status,
  input  logic [tcw_pkg::KIND_W-1:0]     kind,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::IDX_W-1:0]      cell_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcw_pkg::DATA_W-1:0]     cell_data,
  output logic [tcw_pkg::ROW_OUT_W-1:0]  cursor_row,
  output logic [tcw_pkg::COL_OUT_W-1:0]  cursor_col
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * LINES;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(LINES);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int SUM_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;
  // Reciprocal for the quotient of the read index by the row length.
  localparam int DIV_S  = IDX_W + COL_W;
  localparam int DIV_M  = ((1 << DIV_S) + COLUMNS - 1) / COLUMNS;
  localparam int PROD_W = IDX_W + DIV_S + 1;

  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(LINES - 1);
  localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W:0]    LINES_X  = (ROW_W + 1)'(LINES);
  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
  localparam logic [SUM_W-1:0]  CELLS_S  = SUM_W'(CELLS);
  localparam logic [PROD_W-1:0] RECIP    = PROD_W'(DIV_M);

  // Held request.
  logic [KIND_W-1:0] item_kind;
  logic [CHAR_W-1:0] item_char;
  logic [IDX_W-1:0]  item_idx;

  // Cursor and scroll position of the ring of rows.
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  top, top_next;
  logic [ADDR_W-1:0] top_base, top_base_next;
  logic [LINES-1:0]  row_valid;
  logic [COL_W-1:0]  fill_col;

  // Read path.
  logic [ROW_W-1:0]  quot;
  logic              rd_in_range;
  logic              rd_row_ok;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] rd_cell;

  logic [DATA_W-1:0] screen_mem [CELLS];

  logic              is_put, is_lf, is_cr, is_bs, printable;
  logic              advance_row, scroll, clear_all;
  logic [ROW_W-1:0]  prow_cur, rprow;
  logic              cur_row_valid;
  logic [COL_W-1:0]  wcol;
  logic [ADDR_W-1:0] waddr, raddr;
  logic              wen;
  logic [DATA_W-1:0] wdata;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  rsum;
  logic              in_range;

  // Logical row plus ring offset, folded back into the screen.
  function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W-1:0] a,
                                                input logic [ROW_W-1:0] b);
    logic [ROW_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= LINES_X) begin
      return ROW_W'(s - LINES_X);
    end
    return s[ROW_W-1:0];
  endfunction

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind <= kind;
      item_char <= char_code;
      item_idx  <= cell_index;
    end
  end

  // Decode of the held request.
  assign is_put    = (item_kind == KIND_PUT);
  assign is_lf     = (item_char == CH_LF);
  assign is_cr     = (item_char == CH_CR);
  assign is_bs     = (item_char == CH_BS);
  assign printable = !(is_lf || is_cr || is_bs);

  assign prow_cur      = wrap_row(row, top);
  assign cur_row_valid = row_valid[prow_cur];

  assign status.need_fill = is_put && printable && !cur_row_valid;
  assign status.is_read   = (item_kind == KIND_READ);
  assign status.fill_last = (fill_col == LAST_COL);
  assign status.out_free  = !out_valid || !out_stall;

  // Cursor movement, wrapping, scrolling and clearing.
  always_comb begin
    row_next      = row;
    col_next      = col;
    top_next      = top;
    top_base_next = top_base;
    advance_row   = 1'b0;
    scroll        = 1'b0;
    clear_all     = 1'b0;
    if (is_put) begin
      if (is_lf) begin
        advance_row = 1'b1;
      end else if (is_cr) begin
        col_next = '0;
      end else if (is_bs) begin
        if (col != '0) begin
          col_next = COL_W'(col - 1'b1);
        end
      end else if (col == LAST_COL) begin
        advance_row = 1'b1;
      end else begin
        col_next = COL_W'(col + 1'b1);
      end
      if (advance_row) begin
        col_next = '0;
        if (row == LAST_ROW) begin
          // The top row becomes the new bottom row.
          scroll = 1'b1;
          if (top == LAST_ROW) begin
            top_next      = '0;
            top_base_next = '0;
          end else begin
            top_next      = ROW_W'(top + 1'b1);
            top_base_next = ADDR_W'(top_base + COLS_A);
          end
        end else begin
          row_next = ROW_W'(row + 1'b1);
        end
      end
    end else if (item_kind == KIND_CLEAR) begin
      clear_all     = 1'b1;
      row_next      = '0;
      col_next      = '0;
      top_next      = '0;
      top_base_next = '0;
    end
  end

  // Cursor and ring registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      top      <= '0;
      top_base <= '0;
    end else if (cmd.exec) begin
      row      <= row_next;
      col      <= col_next;
      top      <= top_next;
      top_base <= top_base_next;
    end
  end

  // Row flags: a row whose flag is low reads as blank throughout.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.exec && clear_all) begin
      row_valid <= '0;
    end else begin
      if (cmd.fill_step && status.fill_last) begin
        row_valid[prow_cur] <= 1'b1;
      end
      if (cmd.exec && scroll) begin
        row_valid[top] <= 1'b0;
      end
    end
  end

  // Column counter of the row sweep.
  always_ff @(posedge clk) begin
    if (cmd.start_fill) begin
      fill_col <= '0;
    end else if (cmd.fill_step) begin
      fill_col <= COL_W'(fill_col + 1'b1);
    end
  end

  // Write port: row sweep, printed byte or blank left by a backspace.
  assign wcol  = cmd.fill_step ? fill_col : (is_bs ? COL_W'(col - 1'b1) : col);
  assign waddr = ADDR_W'(prow_cur) * COLS_A + ADDR_W'(wcol);
  assign wen   = cmd.fill_step ||
                 (cmd.exec && is_put && cur_row_valid && (printable || (is_bs && col != '0)));
  assign wdata = (cmd.exec && printable) ? {TEXT_ATTR, item_char} : BLANK_CELL;

  always_ff @(posedge clk) begin
    if (wen) begin
      screen_mem[waddr] <= wdata;
    end
  end

  // Row of the read index by reciprocal multiplication.
  assign prod = PROD_W'(item_idx) * RECIP;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quot <= prod[DIV_S +: ROW_W];
    end
  end

  // Physical address and row of the read index.
  assign rsum     = SUM_W'(item_idx) + SUM_W'(top_base);
  assign in_range = (SUM_W'(item_idx) < CELLS_S);
  assign raddr    = (rsum >= CELLS_S) ? ADDR_W'(rsum - CELLS_S) : ADDR_W'(rsum);
  assign rprow    = wrap_row(quot, top);

  always_ff @(posedge clk) begin
    if (cmd.rd_capture) begin
      rd_data     <= screen_mem[raddr];
      rd_in_range <= in_range;
      rd_row_ok   <= in_range && row_valid[rprow];
    end
  end

  always_comb begin
    if (!rd_in_range) begin
      rd_cell = '0;
    end else if (rd_row_ok) begin
      rd_cell = rd_data;
    end else begin
      rd_cell = BLANK_CELL;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.load_read) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cell_data  <= '0;
      cursor_row <= ROW_OUT_W'(row_next);
      cursor_col <= COL_OUT_W'(col_next);
    end else if (cmd.load_read) begin
      cell_data  <= rd_cell;
      cursor_row <= ROW_OUT_W'(row);
      cursor_col <= COL_OUT_W'(col);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/text_console_writer.sv]
// Channel   Handshake               Fields
// request   in_valid / in_stall     kind, char_code, cell_index
// result    out_valid / out_stall   cell_data, cursor_row, cursor_col
//
// A put, clear or idle kind is accepted, then executed; a read also finds the
// index row by multiplication, reads the memory and loads the result. The first
// printable byte into a row marked blank first sweeps that row, column by column
// after a start step, through the single write port of the screen memory.
// Scroll and clear take no sweep: rows sit in a ring with one flag each, reset
// clears the flags at once and there is no clearing pass. A held result stalls
// only the next request's end.
`default_nettype none
`include "text_console_writer_assert.svh"

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int LINES   = tcw_pkg::DEF_LINES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tcw_pkg::KIND_W-1:0]     kind,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::IDX_W-1:0]      cell_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcw_pkg::DATA_W-1:0]     cell_data,
  output logic [tcw_pkg::ROW_OUT_W-1:0]  cursor_row,
  output logic [tcw_pkg::COL_OUT_W-1:0]  cursor_col
);
  import tcw_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Screen memory, cursor and result register.
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .kind       (kind),
    .char_code  (char_code),
    .cell_index (cell_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_data  (cell_data),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col)
  );

  // A taken request keeps the block busy in the following cycle.
  `TCW_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // A result is never loaded over one that is still held.
  `TCW_ASSERT_IMPL(a_load_needs_room, clk, rst, cmd.exec || cmd.load_read, status.out_free)
  // The reported column always lies on the screen.
  `TCW_ASSERT_IMPL(a_col_on_screen, clk, rst, out_valid, cursor_col < COLUMNS)

endmodule

`default_nettype wire

[dv/text_console_writer_test.sv]
`timescale 1ns / 100ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLS  = DEF_COLUMNS;
  localparam int ROWS  = DEF_LINES;
  localparam int CELLS = COLS * ROWS;

  // Kind code that the block leaves unused and ignores.
  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd3;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TIME  = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_TRIGGER = 120;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } console_request_t;

  typedef struct packed {
    logic [DATA_W-1:0]    data;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
  } console_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    kind = KIND_PUT;
  logic [CHAR_W-1:0]    char_code = '0;
  logic [IDX_W-1:0]     cell_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    cell_data;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [COL_OUT_W-1:0] cursor_col;

  text_console_writer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .char_code  (char_code),
    .cell_index (cell_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_data  (cell_data),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col)
  );

  // Shadow copy of the screen and cursor.
  logic [DATA_W-1:0] screen_shadow [CELLS];
  int                shadow_row;
  int                shadow_col;

  console_request_t pending_requests [$];
  console_result_t  expected_results [$];
  console_request_t active_req;

  int queued_count   = 0;
  int accepted_count = 0;
  int results_seen   = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int rx_cycle       = 0;
  int rx_mode        = 0;

  wire hold_active = (hold_left != 0);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Blank every cell of the shadow screen.
  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = BLANK_CELL;
  endfunction

  // Move to column 0 of the next row, scrolling at the bottom.
  function automatic void line_feed();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
      for (int i = 0; i < COLS; i++) screen_shadow[(ROWS - 1) * COLS + i] = BLANK_CELL;
      shadow_row = ROWS - 1;
    end
  endfunction

  // Apply one request to the shadow state and return the result it yields.
  function automatic console_result_t predict_request(console_request_t req);
    console_result_t res;
    int at;
    res.data = '0;
    case (req.kind)
      KIND_PUT: begin
        if (req.ch == CH_LF) begin
          line_feed();
        end else if (req.ch == CH_BS) begin
          if (shadow_col > 0) begin
            shadow_col--;
            at = shadow_row * COLS + shadow_col;
            if (at < CELLS) screen_shadow[at] = BLANK_CELL;
          end
        end else if (req.ch == CH_CR) begin
          shadow_col = 0;
        end else begin
          at = shadow_row * COLS + shadow_col;
          if (at < CELLS) screen_shadow[at] = {TEXT_ATTR, req.ch};
          shadow_col++;
          if (shadow_col >= COLS) line_feed();
        end
      end
      KIND_CLEAR: begin
        blank_screen();
        shadow_row = 0;
        shadow_col = 0;
      end
      KIND_READ: begin
        if (req.idx < CELLS) res.data = screen_shadow[req.idx];
      end
      default: begin
      end
    endcase
    res.row = shadow_row[ROW_OUT_W-1:0];
    res.col = shadow_col[COL_OUT_W-1:0];
    return res;
  endfunction

  task automatic queue_request(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] ch,
                               input logic [IDX_W-1:0] idx);
    console_request_t req;
    req.kind = k;
    req.ch   = ch;
    req.idx  = idx;
    pending_requests.push_back(req);
    queued_count++;
  endtask

  // Wait until every queued request is in and every result is out.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (accepted_count != queued_count || expected_results.size() != 0);
  endtask

  // Random traffic made mostly of text runs, line feeds and reads, with some noise.
  task automatic queue_random_traffic(input int target);
    int n;
    int len;
    int sel;
    int region;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    logic [KIND_W-1:0] k;
    n = 0;
    while (n < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        // A run of text, sometimes long enough to wrap one or more rows.
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 170) : $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          ch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7E));
          queue_request(KIND_PUT, ch, 11'($urandom));
        end
        n += len;
      end else if (sel < 55) begin
        // Line feeds, enough at times to reach the bottom and scroll.
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) queue_request(KIND_PUT, CH_LF, 11'($urandom));
        n += len;
      end else if (sel < 80) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          region = $urandom_range(0, 3);
          case (region)
            0: idx = 11'($urandom);
            1: idx = 11'($urandom_range(CELLS - 2 * COLS, CELLS - 1));
            2: idx = 11'($urandom_range(CELLS - 10, 2047));
            default: idx = 11'($urandom_range(0, 2 * COLS - 1));
          endcase
          queue_request(KIND_READ, 8'($urandom), idx);
        end
        n += len;
      end else if (sel < 88) begin
        len = $urandom_range(1, 4);
        ch = ($urandom_range(0, 1) == 0) ? CH_CR : CH_BS;
        for (int i = 0; i < len; i++) queue_request(KIND_PUT, ch, 11'($urandom));
        n += len;
      end else if (sel < 92) begin
        queue_request(KIND_CLEAR, 8'($urandom), 11'($urandom));
        n++;
      end else if (sel < 96) begin
        // Ignored kind; it does not count as traffic.
        queue_request(KIND_IDLE, 8'($urandom), 11'($urandom));
      end else begin
        k = 2'($urandom);
        queue_request(k, 8'($urandom), 11'($urandom));
        if (k != KIND_IDLE) n++;
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    blank_screen();
    shadow_row = 0;
    shadow_col = 0;

    // Directed requests: reset contents, extreme bytes, control characters, reads.
    queue_request(KIND_READ,  8'h00, 11'd0);
    queue_request(KIND_PUT,   8'h41, 11'd0);
    queue_request(KIND_PUT,   8'h00, 11'd0);
    queue_request(KIND_PUT,   8'hFF, 11'h7FF);
    queue_request(KIND_READ,  8'h00, 11'd0);
    queue_request(KIND_READ,  8'h00, 11'd1);
    queue_request(KIND_READ,  8'h00, 11'd2);
    queue_request(KIND_PUT,   CH_BS, 11'd0);
    queue_request(KIND_READ,  8'h00, 11'd2);
    queue_request(KIND_PUT,   CH_CR, 11'd0);
    queue_request(KIND_PUT,   CH_BS, 11'd0);
    queue_request(KIND_PUT,   CH_LF, 11'd0);
    queue_request(KIND_PUT,   8'h7F, 11'd0);
    queue_request(KIND_PUT,   8'h80, 11'd0);
    queue_request(KIND_READ,  CH_LF, 11'(COLS));
    queue_request(KIND_READ,  8'hFF, 11'(CELLS - 1));
    queue_request(KIND_READ,  8'h00, 11'(CELLS));
    queue_request(KIND_READ,  8'h00, 11'h7FF);
    queue_request(KIND_IDLE,  8'hFF, 11'h7FF);
    queue_request(KIND_CLEAR, CH_LF, 11'd5);
    queue_request(KIND_READ,  8'h41, 11'd0);
    queue_request(KIND_PUT,   8'h20, 11'h7FF);
    queue_request(KIND_READ,  8'h00, 11'd0);
    wait_for_drain();

    queue_random_traffic(250);
    // The sender pauses here until every result has come back.
    wait_for_drain();
    queue_random_traffic(250);
    wait_for_drain();

    repeat (SETTLE_TIME) @(posedge clk);
    if (error_count == 0) begin
      $display("text_console_writer_test: clean");
    end else begin
      $display("text_console_writer_test: errors");
    end
    $finish;
  end

  // Request driver: bursts of random length with random gaps in between.
  always @(posedge clk) begin
    console_request_t req;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_request(active_req));
        accepted_count++;
      end
      if (in_valid && in_stall) begin
        // The stalled request stays as it is.
      end else if (gap_left > 0 && !hold_active) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_requests.size() > 0) begin
        req = pending_requests.pop_front();
        active_req = req;
        in_valid   <= 1'b1;
        kind       <= req.kind;
        char_code  <= req.ch;
        cell_index <= req.idx;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern, with one long hold-off once traffic is flowing.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_TRIGGER) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        case (rx_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= ((rx_cycle % 8) < 3);
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Result monitor: each result against the oldest expectation.
  always @(posedge clk) begin
    console_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: data %h row %0d col %0d",
                 $time, cell_data, cursor_row, cursor_col);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (cell_data !== want.data) begin
          $display("%0t: cell_data expected %h actual %h", $time, want.data, cell_data);
          error_count++;
        end
        if (cursor_row !== want.row) begin
          $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, cursor_row);
          error_count++;
        end
        if (cursor_col !== want.col) begin
          $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, cursor_col);
          error_count++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_console_writer_test: errors");
      $finish;
    end
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_dp.sv
hw/rtl/text_console_writer.sv
dv/text_console_writer_test.sv
